### hw/rtl/lss_pkg.sv
// ----------------------------------------------------------------------------
// lss_pkg: shared types and constants of the token scanner
// States, token classes, record slot type and character class helpers.
// ----------------------------------------------------------------------------
package lss_pkg;

	localparam int LINE_BITS  = 16;
	localparam int WORD_COUNT = 16;
	localparam int MAX_REC    = 5;
	localparam int REC_IDX_W  = 3;

	typedef enum logic [4:0] {
		S_START    = 5'd0,
		S_MINUS    = 5'd1,
		S_CMT1     = 5'd2,
		S_CMT2     = 5'd3,
		S_LINECMT  = 5'd4,
		S_BLOCK    = 5'd5,
		S_BLOCKEND = 5'd6,
		S_IDENT    = 5'd7,
		S_STRING   = 5'd8,
		S_ESCAPE   = 5'd9,
		S_ZEROS    = 5'd10,
		S_INT      = 5'd11,
		S_FRAC1    = 5'd12,
		S_FRAC     = 5'd13,
		S_EXP1     = 5'd14,
		S_EXPSIGN  = 5'd15,
		S_EXPZERO  = 5'd16,
		S_EXPDIG   = 5'd17,
		S_DOT      = 5'd18,
		S_CMP      = 5'd19,
		S_TILDE    = 5'd20
	} scan_state_t;

	typedef enum logic [1:0] {
		RM_NONE  = 2'd0,
		RM_DELIM = 2'd1,
		RM_QUOTE = 2'd2,
		RM_SPARE = 2'd3
	} recovery_t;

	localparam logic [3:0] C_IDENT = 4'd0;
	localparam logic [3:0] C_KEY   = 4'd1;
	localparam logic [3:0] C_LOGIC = 4'd2;
	localparam logic [3:0] C_NIL   = 4'd3;
	localparam logic [3:0] C_INT   = 4'd4;
	localparam logic [3:0] C_REAL  = 4'd5;
	localparam logic [3:0] C_STR   = 4'd6;
	localparam logic [3:0] C_OP    = 4'd7;
	localparam logic [3:0] C_END   = 4'd8;

	typedef struct packed {
		logic       kind;
		logic [7:0] attr;
		logic [3:0] cls;
		logic       err;
	} rec_t;

	typedef struct packed {
		scan_state_t state;
		recovery_t   rmode;
		logic        real_seen;
		logic [15:0] word_match;
		logic [3:0]  word_pos;
		logic [9:0]  esc_acc;
		logic [1:0]  esc_digits;
	} scan_regs_t;

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_delim(input logic [7:0] c);
		logic r;
		r = is_space(c);
		case (c) inside
			"+", "*", "/", "^", "(", ")", ";", ",", ".", "=", "<", ">", "~", "#", "%": r = 1'b1;
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] word_len(input logic [3:0] w);
		logic [3:0] r;
		case (w)
			4'd0, 4'd1: r = 4'd2;
			4'd2, 4'd3, 4'd5, 4'd9: r = 4'd4;
			4'd4, 4'd7, 4'd8, 4'd10, 4'd14: r = 4'd5;
			4'd6, 4'd15: r = 4'd3;
			4'd11: r = 4'd8;
			default: r = 4'd6;
		endcase
		return r;
	endfunction

	// Keyword character at a position; zero past the end of the word.
	function automatic logic [7:0] word_char(input logic [3:0] w, input logic [3:0] p);
		logic [63:0] s;
		logic [7:0] r;
		case (w)
			4'd0:  s = "do";
			4'd1:  s = "if";
			4'd2:  s = "then";
			4'd3:  s = "else";
			4'd4:  s = "local";
			4'd5:  s = "true";
			4'd6:  s = "end";
			4'd7:  s = "while";
			4'd8:  s = "false";
			4'd9:  s = "read";
			4'd10: s = "write";
			4'd11: s = "function";
			4'd12: s = "return";
			4'd13: s = "repeat";
			4'd14: s = "until";
			default: s = "nil";
		endcase
		r = 8'd0;
		if (p < word_len(w)) r = s[8*(word_len(w) - p) - 1 -: 8];
		return r;
	endfunction

endpackage

### hw/rtl/lss_core.sv
// ----------------------------------------------------------------------------
// lss_core: next-state and record logic of the scanner
// Combinational: one byte, the scanner registers in; new registers and up to
// five records out. A terminating byte is scanned a second time here.
// ----------------------------------------------------------------------------
module lss_core
	import lss_pkg::*;
(
	input  logic [7:0]           char_code,
	input  logic                 end_of_input,
	input  scan_regs_t           cur,
	output scan_regs_t           nxt,
	output rec_t [MAX_REC-1:0]   recs,
	output logic [REC_IDX_W-1:0] nrec
);

	// Working copies shared by the scan block and its helpers.
	scan_regs_t r;
	logic [7:0] c;
	logic       e;

	function automatic void push(input rec_t x);
		if (nrec < REC_IDX_W'(MAX_REC)) begin
			recs[nrec] = x;
			nrec = nrec + 1'b1;
		end
	endfunction

	function automatic void push_attr(input logic [7:0] b);
		rec_t x;
		x = '0;
		x.attr = b;
		push(x);
	endfunction

	function automatic void push_end(input logic [3:0] cls, input logic err);
		rec_t x;
		x = '0;
		x.kind = 1'b1;
		x.cls = cls;
		x.err = err;
		push(x);
		r.state = S_START;
		r.real_seen = 1'b0;
		r.esc_digits = 2'd0;
	endfunction

	function automatic logic fail_delim();
		push_end(C_IDENT, 1'b1);
		if (!is_delim(c)) r.rmode = RM_DELIM;
		return is_delim(c);
	endfunction

	function automatic void fail_quote();
		push_end(C_IDENT, 1'b1);
		if (c != "\"") r.rmode = RM_QUOTE;
	endfunction

	function automatic void match_upd();
		for (int i = 0; i < WORD_COUNT; i++)
			if (r.word_pos >= word_len(4'(i)) || word_char(4'(i), r.word_pos) != c)
				r.word_match[i] = 1'b0;
		if (r.word_pos != 4'd15) r.word_pos = r.word_pos + 4'd1;
	endfunction

	always_comb begin
		logic again;
		logic go;
		logic [3:0] wcls;
		logic [9:0] acc;
		c = char_code;
		e = end_of_input;
		r = cur;
		recs = '0;
		nrec = '0;
		go = 1'b1;
		again = 1'b0;
		wcls = C_IDENT;
		acc = '0;

		// Recovery modes drop bytes before any scanning.
		case (r.rmode)
			RM_DELIM: begin
				if (!e && !is_delim(c)) go = 1'b0;
				else begin
					r.rmode = RM_NONE;
					r.state = S_START;
				end
			end
			RM_QUOTE: begin
				go = 1'b0;
				if (e || c == "\"") begin
					r.rmode = RM_NONE;
					r.state = S_START;
				end
				if (e) go = 1'b1;
			end
			RM_SPARE: r.rmode = RM_NONE;
			default: ;
		endcase

		for (int pass = 0; pass < 2; pass++) begin
			again = 1'b0;
			if (go) begin
				case (r.state)
					S_MINUS: begin
						if (!e && c == "-") r.state = S_CMT1;
						else begin
							push_attr("-");
							push_end(C_OP, 1'b0);
							again = 1'b1;
						end
					end
					S_CMT1, S_CMT2: begin
						if (e) push_end(C_END, 1'b0);
						else if (c == "[") r.state = (r.state == S_CMT1) ? S_CMT2 : S_BLOCK;
						else if (c == 8'd10) r.state = S_START;
						else r.state = S_LINECMT;
					end
					S_LINECMT: begin
						if (e) push_end(C_END, 1'b0);
						else if (c == 8'd10) r.state = S_START;
					end
					S_BLOCK, S_BLOCKEND: begin
						if (e) push_end(C_END, 1'b1);
						else if (c == "]") r.state = (r.state == S_BLOCK) ? S_BLOCKEND : S_START;
						else r.state = S_BLOCK;
					end
					S_IDENT: begin
						if (!e && (is_alpha(c) || is_digit(c) || c == "_")) begin
							match_upd();
							push_attr(c);
						end else begin
							wcls = C_IDENT;
							for (int i = WORD_COUNT - 1; i >= 0; i--)
								if (r.word_match[i] && word_len(4'(i)) == r.word_pos)
									wcls = (i == 5 || i == 8) ? C_LOGIC :
									       (i == 15) ? C_NIL : C_KEY;
							push_end(wcls, 1'b0);
							again = 1'b1;
						end
					end
					S_STRING: begin
						if (e) push_end(C_END, 1'b1);
						else if (c == "\"") push_end(C_STR, 1'b0);
						else if (c == "\\") begin
							r.state = S_ESCAPE;
							r.esc_digits = 2'd0;
						end else if (c == 8'd0) fail_quote();
						else push_attr(c);
					end
					S_ESCAPE: begin
						acc = 10'(r.esc_acc * 10) + 10'(c - "0");
						if (e) push_end(C_END, 1'b1);
						else if (r.esc_digits == 2'd1) begin
							if (is_digit(c)) begin
								r.esc_acc = acc;
								r.esc_digits = 2'd2;
							end else fail_quote();
						end else if (r.esc_digits == 2'd2) begin
							if (!is_digit(c)) again = fail_delim();
							else begin
								r.esc_acc = acc;
								push_attr(acc[7:0]);
								r.esc_digits = 2'd0;
								r.state = S_STRING;
							end
						end else begin
							r.esc_digits = 2'd0;
							if (c == "n") begin
								push_attr(8'd10);
								r.state = S_STRING;
							end else if (c == "t") begin
								push_attr(8'd9);
								r.state = S_STRING;
							end else if (c == "\\" || c == "\"") begin
								push_attr(c);
								r.state = S_STRING;
							end else if (is_digit(c)) begin
								r.esc_acc = 10'(c - "0");
								r.esc_digits = 2'd1;
							end else fail_quote();
						end
					end
					S_ZEROS: begin
						if (!e && c == "0") ;
						else if (!e && is_digit(c)) begin
							push_attr(c);
							r.state = S_INT;
						end else if (!e && c == ".") begin
							push_attr("0");
							push_attr(c);
							r.state = S_FRAC1;
						end else if (!e && (c == "e" || c == "E")) begin
							push_attr("0");
							push_attr(c);
							r.state = S_EXP1;
						end else begin
							push_attr("0");
							push_end(C_INT, 1'b0);
							again = 1'b1;
						end
					end
					S_INT: begin
						if (!e && c == ".") begin
							push_attr(c);
							r.state = S_FRAC1;
						end else if (!e && (c == "e" || c == "E")) begin
							push_attr(c);
							r.state = S_EXP1;
						end else if (!e && is_digit(c)) push_attr(c);
						else begin
							push_end(C_INT, 1'b0);
							again = 1'b1;
						end
					end
					S_FRAC1: begin
						if (e) push_end(C_END, 1'b1);
						else if (is_digit(c)) begin
							push_attr(c);
							r.state = S_FRAC;
						end else again = fail_delim();
					end
					S_FRAC: begin
						if (!e && (c == "e" || c == "E")) begin
							push_attr(c);
							r.real_seen = 1'b1;
							r.state = S_EXP1;
						end else if (!e && is_digit(c)) push_attr(c);
						else begin
							push_end(C_REAL, 1'b0);
							again = 1'b1;
						end
					end
					S_EXP1, S_EXPSIGN: begin
						if (e) push_end(C_END, 1'b1);
						else if (r.state == S_EXP1 && (c == "+" || c == "-")) begin
							push_attr(c);
							r.state = S_EXPSIGN;
						end else if (c == "0") r.state = S_EXPZERO;
						else if (is_digit(c)) begin
							push_attr(c);
							r.state = S_EXPDIG;
						end else again = fail_delim();
					end
					S_EXPZERO: begin
						if (!e && c == "0") ;
						else if (!e && is_digit(c)) begin
							push_attr(c);
							r.state = S_EXPDIG;
						end else begin
							push_attr("0");
							push_end(r.real_seen ? C_REAL : C_INT, 1'b0);
							again = 1'b1;
						end
					end
					S_EXPDIG: begin
						if (!e && is_digit(c)) push_attr(c);
						else begin
							push_end(r.real_seen ? C_REAL : C_INT, 1'b0);
							again = 1'b1;
						end
					end
					S_DOT: begin
						if (e) push_end(C_END, 1'b1);
						else if (c == ".") begin
							push_attr(c);
							push_end(C_OP, 1'b0);
						end else again = fail_delim();
					end
					S_CMP: begin
						if (!e && c == "=") begin
							push_attr(c);
							push_end(C_OP, 1'b0);
						end else begin
							push_end(C_OP, 1'b0);
							again = 1'b1;
						end
					end
					S_TILDE: begin
						if (e) push_end(C_END, 1'b1);
						else if (c == "=") begin
							push_attr(c);
							push_end(C_OP, 1'b0);
						end else again = fail_delim();
					end
					default: begin
						r.state = S_START;
						r.real_seen = 1'b0;
						if (e) push_end(C_END, 1'b0);
						else if (is_space(c)) ;
						else if (c == "-") r.state = S_MINUS;
						else if (is_alpha(c) || c == "_") begin
							r.word_match = '1;
							r.word_pos = '0;
							match_upd();
							push_attr(c);
							r.state = S_IDENT;
						end else if (c == "\"") begin
							r.state = S_STRING;
							r.esc_digits = 2'd0;
						end else if (c == "0") r.state = S_ZEROS;
						else if (is_digit(c)) begin
							push_attr(c);
							r.state = S_INT;
						end else begin
							case (c) inside
								"+", "*", "/", "^", "(", ")", ";", ",", "#", "%": begin
									push_attr(c);
									push_end(C_OP, 1'b0);
								end
								".": begin
									push_attr(c);
									r.state = S_DOT;
								end
								"=", "<", ">": begin
									push_attr(c);
									r.state = S_CMP;
								end
								"~": begin
									push_attr(c);
									r.state = S_TILDE;
								end
								default: push_end(C_IDENT, 1'b1);
							endcase
						end
					end
				endcase
			end
			go = again;
		end
		nxt = r;
	end

endmodule

### hw/rtl/lua_subset_token_scanner.sv
// ----------------------------------------------------------------------------
// lua_subset_token_scanner: byte-serial token scanner
// Skips whitespace and comments, reports attribute bytes and token classes.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  in       | in_valid/in_ready   | char_code, end_of_input
//  out      | out_valid/out_ready | record_kind, attr_byte, token_class,
//           |                     | error_flag, line_number, last
//
// A byte is scanned in the cycle it is accepted; its records (up to five) go
// to a record buffer and leave one per cycle while out_ready is high. Most
// bytes give at most one record, so the input then takes one byte per cycle;
// a byte that gives more holds the input until its last record leaves. Reset
// puts the scanner in the start state at line one with an empty buffer.
module lua_subset_token_scanner
	import lss_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	input  logic       end_of_input,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       record_kind,
	output logic [7:0] attr_byte,
	output logic [3:0] token_class,
	output logic       error_flag,
	output logic [15:0] line_number,
	output logic       last
);

	scan_regs_t           regs_q, regs_nxt;
	logic [LINE_BITS-1:0] line_q, line_nxt;
	rec_t [MAX_REC-1:0]   recs, buf_q;
	logic [REC_IDX_W-1:0] nrec, cnt_q, rd_q;
	logic [LINE_BITS-1:0] bline_q;
	logic                 take, pop, at_last;

	lss_core u_core (
		.char_code    (char_code),
		.end_of_input (end_of_input),
		.cur          (regs_q),
		.nxt          (regs_nxt),
		.recs         (recs),
		.nrec         (nrec)
	);

	assign out_valid = cnt_q != '0;
	assign at_last   = rd_q == cnt_q - 1'b1;
	assign pop       = out_valid && out_ready;
	// The buffer is free when empty or when its last beat leaves this cycle.
	assign in_ready  = !out_valid || (pop && at_last);
	assign take      = in_valid && in_ready;

	always_comb begin
		line_nxt = line_q;
		if (!end_of_input && char_code == 8'd10 && line_q != '1) line_nxt = line_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '{state: S_START, rmode: RM_NONE, real_seen: 1'b0,
			            word_match: '1, word_pos: '0, esc_acc: '0, esc_digits: '0};
			line_q <= LINE_BITS'(1);
			cnt_q  <= '0;
			rd_q   <= '0;
		end else if (take) begin
			regs_q <= regs_nxt;
			line_q <= line_nxt;
			cnt_q  <= nrec;
			rd_q   <= '0;
		end else if (pop) begin
			if (at_last) cnt_q <= '0;
			rd_q <= rd_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			buf_q   <= recs;
			bline_q <= line_nxt;
		end
	end

	always_comb begin
		rec_t cur;
		cur = buf_q[rd_q];
		record_kind = cur.kind;
		attr_byte   = cur.attr;
		token_class = cur.cls;
		error_flag  = cur.err;
		line_number = bline_q[15:0];
		last        = at_last;
	end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench of the byte-serial token scanner
// Drives bytes and end marks through a valid/ready channel, predicts every
// record with a behavioral scanner model and compares each output beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
	import lss_pkg::*;

	typedef struct packed {
		logic        kind;
		logic [7:0]  attr;
		logic [3:0]  cls;
		logic        err;
		logic [15:0] line;
		logic        last;
	} scan_rec_t;

	typedef struct {
		logic [7:0] c;
		logic       e;
		int         n_typed;
		scan_rec_t  typed;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] char_code = 8'd0;
	logic end_of_input = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic record_kind;
	logic [7:0] attr_byte;
	logic [3:0] token_class;
	logic error_flag;
	logic [15:0] line_number;
	logic last;

	lua_subset_token_scanner dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.char_code(char_code), .end_of_input(end_of_input),
		.out_valid(out_valid), .out_ready(out_ready),
		.record_kind(record_kind), .attr_byte(attr_byte),
		.token_class(token_class), .error_flag(error_flag),
		.line_number(line_number), .last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state.
	scan_state_t st;
	recovery_t   rmode;
	logic [15:0] lines;
	logic        frac_seen;
	logic [15:0] kw_match;
	logic [3:0]  kw_pos;
	logic [9:0]  esc_val;
	logic [1:0]  esc_cnt;

	scan_rec_t pending_recs[$];
	scan_rec_t step_recs[$];
	int errors = 0;
	int cycle = 0;
	int in_idle_pct = 0;
	int out_stall_pct = 0;
	bit hold_out = 1'b0;
	bit done = 1'b0;

	function automatic string kw_text(int i);
		case (i)
			0: return "do";       1: return "if";     2: return "then";
			3: return "else";     4: return "local";  5: return "true";
			6: return "end";      7: return "while";  8: return "false";
			9: return "read";     10: return "write"; 11: return "function";
			12: return "return";  13: return "repeat"; 14: return "until";
			default: return "nil";
		endcase
	endfunction

	function automatic bit sp(logic [7:0] c);
		return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
	endfunction
	function automatic bit dig(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction
	function automatic bit alp(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction
	function automatic bit delim(logic [7:0] c);
		return sp(c) || c == "+" || c == "*" || c == "/" || c == "^" || c == "("
			|| c == ")" || c == ";" || c == "," || c == "." || c == "="
			|| c == "<" || c == ">" || c == "~" || c == "#" || c == "%";
	endfunction

	task automatic push_rec(logic k, logic [7:0] a, logic [3:0] cl, logic er);
		scan_rec_t r;
		if (step_recs.size() >= MAX_REC) return;
		r.kind = k; r.attr = a; r.cls = cl; r.err = er; r.line = lines; r.last = 1'b0;
		step_recs.push_back(r);
	endtask

	task automatic put_attr(logic [7:0] a);
		push_rec(1'b0, a, C_IDENT, 1'b0);
	endtask

	task automatic close_tok(logic [3:0] cl, logic er);
		push_rec(1'b1, 8'd0, cl, er);
		st = S_START;
		frac_seen = 1'b0;
		esc_cnt = 2'd0;
	endtask

	task automatic err_delim(logic [7:0] c, output bit again);
		close_tok(C_IDENT, 1'b1);
		again = delim(c);
		if (!again) rmode = RM_DELIM;
	endtask

	task automatic err_quote(logic [7:0] c);
		close_tok(C_IDENT, 1'b1);
		if (c != "\"") rmode = RM_QUOTE;
	endtask

	task automatic kw_advance(logic [7:0] c);
		string s;
		for (int i = 0; i < WORD_COUNT; i++) begin
			s = kw_text(i);
			if (kw_match[i] && (kw_pos >= s.len() || s[kw_pos] != c))
				kw_match[i] = 1'b0;
		end
		if (kw_pos < 4'd15) kw_pos++;
	endtask

	function automatic logic [3:0] kw_class();
		string s;
		for (int i = 0; i < WORD_COUNT; i++) begin
			s = kw_text(i);
			if (kw_match[i] && s.len() == kw_pos) begin
				if (i == 5 || i == 8) return C_LOGIC;
				if (i == 15) return C_NIL;
				return C_KEY;
			end
		end
		return C_IDENT;
	endfunction

	// One scan pass; again is set when the byte must go through the start state.
	task automatic scan_byte(logic [7:0] c, logic e, output bit again);
		logic [7:0] d;
		d = c - "0";
		again = 1'b0;
		case (st)
			S_MINUS: begin
				if (!e && c == "-") st = S_CMT1;
				else begin
					put_attr("-"); close_tok(C_OP, 1'b0); again = 1'b1;
				end
				return;
			end
			S_CMT1, S_CMT2: begin
				if (e) close_tok(C_END, 1'b0);
				else if (c == "[") st = (st == S_CMT1) ? S_CMT2 : S_BLOCK;
				else if (c == 8'd10) st = S_START;
				else st = S_LINECMT;
				return;
			end
			S_LINECMT: begin
				if (e) close_tok(C_END, 1'b0);
				else if (c == 8'd10) st = S_START;
				return;
			end
			S_BLOCK, S_BLOCKEND: begin
				if (e) close_tok(C_END, 1'b1);
				else if (c == "]") st = (st == S_BLOCK) ? S_BLOCKEND : S_START;
				else st = S_BLOCK;
				return;
			end
			S_IDENT: begin
				if (!e && (alp(c) || dig(c) || c == "_")) begin
					kw_advance(c); put_attr(c);
				end else begin
					close_tok(kw_class(), 1'b0); again = 1'b1;
				end
				return;
			end
			S_STRING: begin
				if (e) close_tok(C_END, 1'b1);
				else if (c == "\"") close_tok(C_STR, 1'b0);
				else if (c == "\\") begin
					st = S_ESCAPE; esc_cnt = 2'd0;
				end else if (c == 8'd0) err_quote(c);
				else put_attr(c);
				return;
			end
			S_ESCAPE: begin
				if (e) close_tok(C_END, 1'b1);
				else if (esc_cnt == 2'd1) begin
					if (dig(c)) begin
						esc_val = esc_val * 10 + d; esc_cnt = 2'd2;
					end else err_quote(c);
				end else if (esc_cnt == 2'd2) begin
					if (!dig(c)) err_delim(c, again);
					else begin
						esc_val = esc_val * 10 + d;
						put_attr(esc_val[7:0]);
						esc_cnt = 2'd0; st = S_STRING;
					end
				end else begin
					esc_cnt = 2'd0;
					if (c == "n") begin put_attr(8'd10); st = S_STRING; end
					else if (c == "t") begin put_attr(8'd9); st = S_STRING; end
					else if (c == "\\" || c == "\"") begin put_attr(c); st = S_STRING; end
					else if (dig(c)) begin esc_val = {2'b0, d}; esc_cnt = 2'd1; end
					else err_quote(c);
				end
				return;
			end
			S_ZEROS: begin
				if (!e && c == "0") ;
				else if (!e && dig(c)) begin put_attr(c); st = S_INT; end
				else if (!e && c == ".") begin put_attr("0"); put_attr(c); st = S_FRAC1; end
				else if (!e && (c == "e" || c == "E")) begin
					put_attr("0"); put_attr(c); st = S_EXP1;
				end else begin
					put_attr("0"); close_tok(C_INT, 1'b0); again = 1'b1;
				end
				return;
			end
			S_INT: begin
				if (!e && c == ".") begin put_attr(c); st = S_FRAC1; end
				else if (!e && (c == "e" || c == "E")) begin put_attr(c); st = S_EXP1; end
				else if (!e && dig(c)) put_attr(c);
				else begin close_tok(C_INT, 1'b0); again = 1'b1; end
				return;
			end
			S_FRAC1: begin
				if (e) close_tok(C_END, 1'b1);
				else if (dig(c)) begin put_attr(c); st = S_FRAC; end
				else err_delim(c, again);
				return;
			end
			S_FRAC: begin
				if (!e && (c == "e" || c == "E")) begin
					put_attr(c); frac_seen = 1'b1; st = S_EXP1;
				end else if (!e && dig(c)) put_attr(c);
				else begin close_tok(C_REAL, 1'b0); again = 1'b1; end
				return;
			end
			S_EXP1, S_EXPSIGN: begin
				if (e) close_tok(C_END, 1'b1);
				else if (st == S_EXP1 && (c == "+" || c == "-")) begin
					put_attr(c); st = S_EXPSIGN;
				end else if (c == "0") st = S_EXPZERO;
				else if (dig(c)) begin put_attr(c); st = S_EXPDIG; end
				else err_delim(c, again);
				return;
			end
			S_EXPZERO: begin
				if (!e && c == "0") ;
				else if (!e && dig(c)) begin put_attr(c); st = S_EXPDIG; end
				else begin
					put_attr("0"); close_tok(frac_seen ? C_REAL : C_INT, 1'b0); again = 1'b1;
				end
				return;
			end
			S_EXPDIG: begin
				if (!e && dig(c)) put_attr(c);
				else begin close_tok(frac_seen ? C_REAL : C_INT, 1'b0); again = 1'b1; end
				return;
			end
			S_DOT, S_TILDE: begin
				if (e) close_tok(C_END, 1'b1);
				else if (c == ((st == S_DOT) ? 8'h2e : 8'h3d)) begin
					put_attr(c); close_tok(C_OP, 1'b0);
				end else err_delim(c, again);
				return;
			end
			S_CMP: begin
				if (!e && c == "=") begin put_attr(c); close_tok(C_OP, 1'b0); end
				else begin close_tok(C_OP, 1'b0); again = 1'b1; end
				return;
			end
			default: ;
		endcase
		st = S_START;
		frac_seen = 1'b0;
		if (e) close_tok(C_END, 1'b0);
		else if (sp(c)) ;
		else if (c == "-") st = S_MINUS;
		else if (alp(c) || c == "_") begin
			kw_match = 16'hFFFF; kw_pos = 4'd0;
			kw_advance(c); put_attr(c); st = S_IDENT;
		end else if (c == "\"") begin st = S_STRING; esc_cnt = 2'd0; end
		else if (c == "0") st = S_ZEROS;
		else if (dig(c)) begin put_attr(c); st = S_INT; end
		else if (c == "+" || c == "*" || c == "/" || c == "^" || c == "(" || c == ")"
				|| c == ";" || c == "," || c == "#" || c == "%") begin
			put_attr(c); close_tok(C_OP, 1'b0);
		end else if (c == ".") begin put_attr(c); st = S_DOT; end
		else if (c == "=" || c == "<" || c == ">") begin put_attr(c); st = S_CMP; end
		else if (c == "~") begin put_attr(c); st = S_TILDE; end
		else close_tok(C_IDENT, 1'b1);
	endtask

	task automatic predict_records(logic [7:0] c, logic e);
		bit again;
		step_recs.delete();
		if (!e && c == 8'd10 && lines != 16'hFFFF) lines++;
		if (rmode == RM_DELIM) begin
			if (!e && !delim(c)) return;
			rmode = RM_NONE; st = S_START;
		end else if (rmode == RM_QUOTE) begin
			if (!e) begin
				if (c == "\"") begin rmode = RM_NONE; st = S_START; end
				return;
			end
			rmode = RM_NONE; st = S_START;
		end else if (rmode != RM_NONE) rmode = RM_NONE;
		scan_byte(c, e, again);
		if (again) scan_byte(c, e, again);
		if (step_recs.size() > 0) step_recs[step_recs.size() - 1].last = 1'b1;
		foreach (step_recs[i]) pending_recs.push_back(step_recs[i]);
	endtask

	// Called at a falling edge; valid stays high into the next beat unless idling.
	task automatic send_beat(logic [7:0] c, logic e);
		while (in_idle_pct > 0 && $urandom_range(99, 0) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		char_code <= c;
		end_of_input <= e;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_records(c, e);
		@(negedge clk);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (pending_recs.size() > 0) @(posedge clk);
		repeat (10) @(posedge clk);
		@(negedge clk);
	endtask

	// Output side: random stalls, optional long hold-off.
	always @(negedge clk) begin
		if (!arst_n || hold_out) out_ready <= 1'b0;
		else out_ready <= !(out_stall_pct > 0 && $urandom_range(99, 0) < out_stall_pct);
	end

	always @(posedge clk) begin
		scan_rec_t exp_r;
		cycle <= cycle + 1;
		if (arst_n && out_valid && out_ready) begin
			if (pending_recs.size() == 0) begin
				$error("unexpected record beat");
				errors++;
			end else begin
				exp_r = pending_recs.pop_front();
				if (record_kind !== exp_r.kind) begin
					$error("record_kind exp %0d got %0d", exp_r.kind, record_kind); errors++;
				end
				if (attr_byte !== exp_r.attr) begin
					$error("attr_byte exp %0d got %0d", exp_r.attr, attr_byte); errors++;
				end
				if (token_class !== exp_r.cls) begin
					$error("token_class exp %0d got %0d", exp_r.cls, token_class); errors++;
				end
				if (error_flag !== exp_r.err) begin
					$error("error_flag exp %0d got %0d", exp_r.err, error_flag); errors++;
				end
				if (line_number !== exp_r.line) begin
					$error("line_number exp %0d got %0d", exp_r.line, line_number); errors++;
				end
				if (last !== exp_r.last) begin
					$error("last exp %0d got %0d", exp_r.last, last); errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycle > 400000 && !done) begin
			$display("[lua_subset_token_scanner] ERROR");
			$finish;
		end
	end

	// Directed rows; typed expectations only for single obvious records.
	function automatic dir_row_t row(logic [7:0] c, logic e, int n = 0,
			logic k = 0, logic [7:0] a = 0, logic [3:0] cl = 0, logic er = 0,
			logic [15:0] ln = 1);
		dir_row_t r;
		r.c = c; r.e = e; r.n_typed = n;
		r.typed = '{kind: k, attr: a, cls: cl, err: er, line: ln, last: 1'b1};
		return r;
	endfunction

	dir_row_t dir_rows[$];

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
	endtask

	// Random well-formed fragments with random content, plus noise.
	task automatic send_random_chunk();
		int kind;
		string ops;
		kind = $urandom_range(11, 0);
		ops = "+*/^();,#%=<>~.-";
		case (kind)
			0: send_text(kw_text($urandom_range(15, 0)));
			1: begin
				send_beat(8'("a" + $urandom_range(25, 0)), 1'b0);
				repeat ($urandom_range(6, 0)) send_beat("_", 1'b0);
			end
			2: begin
				repeat ($urandom_range(3, 0)) send_beat("0", 1'b0);
				repeat ($urandom_range(3, 0)) send_beat(8'("0" + $urandom_range(9, 0)), 1'b0);
				if ($urandom_range(1, 0)) begin
					send_beat(".", 1'b0);
					repeat ($urandom_range(2, 0))
						send_beat(8'("0" + $urandom_range(9, 0)), 1'b0);
				end
				if ($urandom_range(1, 0)) begin
					send_beat($urandom_range(1, 0) ? "e" : "E", 1'b0);
					if ($urandom_range(1, 0)) send_beat($urandom_range(1, 0) ? "+" : "-", 1'b0);
					repeat ($urandom_range(3, 0))
						send_beat(8'("0" + $urandom_range(2, 0)), 1'b0);
				end
			end
			3: begin
				send_beat("\"", 1'b0);
				repeat ($urandom_range(4, 0)) begin
					case ($urandom_range(5, 0))
						0: send_text("\\n");
						1: begin
							send_beat("\\", 1'b0);
							repeat (3) send_beat(8'("0" + $urandom_range(9, 0)), 1'b0);
						end
						2: send_beat("\\", 1'b0);
						default: send_beat(8'($urandom_range(255, 1)), 1'b0);
					endcase
				end
				send_beat("\"", 1'b0);
			end
			4: send_beat(ops[$urandom_range(ops.len() - 1, 0)], 1'b0);
			5: send_text($urandom_range(1, 0) ? "--x y\n" : "--[[ a]b ]]");
			6: send_beat(" ", 1'b0);
			7: send_beat(8'd10, 1'b0);
			8: send_beat(8'($urandom_range(255, 0)), 1'b0);
			9: send_text($urandom_range(1, 0) ? "~x" : ".y");
			10: send_beat(8'(8'h80 | $urandom_range(127, 0)), 1'b0);
			default: send_beat(8'($urandom_range(255, 0)), $urandom_range(7, 0) == 0);
		endcase
	endtask

	initial begin
		int sent;
		st = S_START; rmode = RM_NONE; lines = 16'd1; frac_seen = 1'b0;
		kw_match = 16'hFFFF; kw_pos = 4'd0; esc_val = '0; esc_cnt = 2'd0;

		dir_rows.push_back(row(8'd0, 1'b0, 1, 1, 0, C_IDENT, 1));
		dir_rows.push_back(row(8'hFF, 1'b0, 1, 1, 0, C_IDENT, 1));
		dir_rows.push_back(row(8'hFF, 1'b1, 1, 1, 0, C_END, 0));
		dir_rows.push_back(row("+", 1'b0));
		dir_rows.push_back(row(8'd10, 1'b0));
		dir_rows.push_back(row("0", 1'b0));
		dir_rows.push_back(row("0", 1'b0));
		dir_rows.push_back(row("e", 1'b0));
		dir_rows.push_back(row("0", 1'b0));
		dir_rows.push_back(row(";", 1'b0));
		dir_rows.push_back(row("\"", 1'b0));
		dir_rows.push_back(row("\\", 1'b0));
		dir_rows.push_back(row("2", 1'b0));
		dir_rows.push_back(row("9", 1'b0));
		dir_rows.push_back(row("9", 1'b0));
		dir_rows.push_back(row("\"", 1'b0));
		dir_rows.push_back(row("n", 1'b0));
		dir_rows.push_back(row("i", 1'b0));
		dir_rows.push_back(row("l", 1'b0));
		dir_rows.push_back(row("<", 1'b0));
		dir_rows.push_back(row("\"", 1'b0));
		dir_rows.push_back(row("\\", 1'b0));
		dir_rows.push_back(row("x", 1'b0));
		dir_rows.push_back(row("a", 1'b0));
		dir_rows.push_back(row(8'h00, 1'b1));

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].n_typed > 0) begin
				// After the first three rows the line is still one.
				send_beat(dir_rows[i].c, dir_rows[i].e);
				if (pending_recs.size() != 1 || pending_recs[0] != dir_rows[i].typed) begin
					$error("typed row %0d expected record mismatch", i);
					errors++;
				end
			end else send_beat(dir_rows[i].c, dir_rows[i].e);
		end
		send_text("function(1.5e-007 2..3 <= 7.x ~= \"a\\1q\" --[[c]] false)");
		send_beat(8'd0, 1'b1);
		wait_drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin in_idle_pct = 0; out_stall_pct = 0; end
				1: begin in_idle_pct = 77; out_stall_pct = 0; end
				2: begin in_idle_pct = 0; out_stall_pct = 77; end
				default: begin in_idle_pct = 13; out_stall_pct = 13; end
			endcase
			sent = 0;
			while (sent < 5) begin
				send_random_chunk();
				sent++;
			end
			if (ph == 0) begin
				// Long output hold-off while tokens keep coming.
				fork
					begin
						hold_out = 1'b1;
						repeat (60) @(posedge clk);
						hold_out = 1'b0;
					end
					send_text("x y z + - 00. \"ab\" end ;;");
				join
				// Sender pauses until everything has drained.
				wait_drain();
			end
		end
		send_beat(8'd0, 1'b1);

		wait_drain();
		done = 1'b1;
		if (errors == 0) $display("[lua_subset_token_scanner] OK");
		else $display("[lua_subset_token_scanner] ERROR");
		$finish;
	end

endmodule
